FILE: sv/ccls_pkg.sv
// ccls_pkg: shared types, codes and character constants for the
// character-counting line sender. No dependencies.
package ccls_pkg;

    // event kinds carried on the input side
    typedef enum logic [1:0] {
        FUNC_LINE_READY = 2'd0,
        FUNC_EXHAUSTED  = 2'd1,
        FUNC_RESPONSE   = 2'd2,
        FUNC_ABORT      = 2'd3
    } func_t;

    // link mode
    typedef enum logic [2:0] {
        MODE_STREAM = 3'd0,
        MODE_AWAIT  = 3'd1,
        MODE_FINISH = 3'd2,
        MODE_DONE   = 3'd3,
        MODE_ERROR  = 3'd4
    } mode_t;

    // error cause
    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_UNKNOWN  = 2'd1,
        CAUSE_ABORT    = 2'd2,
        CAUSE_OVERFLOW = 2'd3
    } cause_t;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // response parser: position saturates after the longest keyword
    localparam logic [2:0] OK_LEN        = 3'd2;
    localparam logic [2:0] ERR_LEN       = 3'd5;
    localparam logic [1:0] MATCH_OK      = 2'b01;
    localparam logic [1:0] MATCH_ERR     = 2'b10;
    localparam logic [1:0] MATCH_ALL     = 2'b11;
    localparam logic [12:0] CREDIT_RESET = 13'd128;

    // queue request from the controller
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_len;
    } q_req_t;

    // queue status toward the controller
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       one_left;
        logic [7:0] head_len;
    } q_stat_t;

    // one result item
    typedef struct packed {
        logic        release_line;
        logic [7:0]  release_length;
        mode_t       mode;
        cause_t      error_cause;
        logic [31:0] lines_sent;
        logic [31:0] lines_done;
    } result_t;

    // characters of "ok"
    function automatic logic [7:0] ok_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h6F;
            3'd1:    ch = 8'h6B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // characters of "error"
    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h6F;
            3'd4:    ch = 8'h72;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: sv/character_counting_line_sender.sv
// Character-counting line sender, top level: input register, controller,
// length queue and result register. Depends on ccls_pkg, ccls_ctrl, ccls_len_queue.
// A request passes through the input register, then its result is held in the result register on m_tvalid.
// Throughput: one request per cycle; the result register frees while m_tready is high, else the input stalls.
// Reset (rst_n, asynchronous): streaming mode, empty queue, counters zero, credit 128.
// The queue memory is not cleared; only entries already written are read.
module character_counting_line_sender #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_LINE    = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: credit_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    // input side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // line_length [7:0], rx_byte [15:8]
    input  logic [1:0]  s_tuser,   // func [1:0]
    // output side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // release_length [7:0], mode [10:8],
                                   // error_cause [12:11], lines_sent [44:13],
                                   // lines_done [76:45], zero [79:77]
    output logic [0:0]  m_tuser    // release_line [0]
);

    logic              in_valid_reg;
    ccls_pkg::func_t   in_func_reg;
    logic [7:0]        in_len_reg;
    logic [7:0]        in_rx_reg;
    logic              advance;
    logic [12:0]       credit_reg;
    logic              out_valid_reg;
    ccls_pkg::result_t out_reg;
    ccls_pkg::result_t result;
    ccls_pkg::q_req_t  q_req;
    ccls_pkg::q_stat_t q_stat;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= ccls_pkg::CREDIT_RESET;
        end
        else if (cfg_valid)
        begin
            credit_reg <= cfg_data;
        end
    end

    // stage handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= ccls_pkg::func_t'(s_tuser);
            in_len_reg  <= s_tdata[7:0];
            in_rx_reg   <= s_tdata[15:8];
        end
    end

    ccls_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_LINE    (MAX_LINE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_valid     (advance),
        .ev_func      (in_func_reg),
        .ev_len       (in_len_reg),
        .ev_rx        (in_rx_reg),
        .credit_limit (credit_reg),
        .q_stat       (q_stat),
        .q_req        (q_req),
        .result       (result)
    );

    ccls_len_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .stat  (q_stat)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    // output packing
    assign m_tvalid       = out_valid_reg;
    assign m_tuser[0]     = out_reg.release_line;
    assign m_tdata[7:0]   = out_reg.release_length;
    assign m_tdata[10:8]  = out_reg.mode;
    assign m_tdata[12:11] = out_reg.error_cause;
    assign m_tdata[44:13] = out_reg.lines_sent;
    assign m_tdata[76:45] = out_reg.lines_done;
    assign m_tdata[79:77] = 3'd0;

endmodule

FILE: sv/ccls_ram.sv
// ccls_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/ccls_len_queue.sv
// ccls_len_queue: circular queue of outstanding line lengths, head entry
// always presented. Depends on ccls_pkg and ccls_ram.
module ccls_len_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ccls_pkg::q_req_t req,
    output ccls_pkg::q_stat_t stat
);

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [ADDR_W-1:0]  tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bypass_reg, bypass_next;
    logic [7:0]         bypass_data_reg;
    logic [7:0]         ram_q;

    // wrapping pointer advance
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointer and count update
    always_comb
    begin
        head_next  = req.pop  ? ptr_inc(head_reg) : head_reg;
        tail_next  = req.push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (req.push && !req.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (req.pop && !req.push)
        begin
            count_next = count_reg - 1'b1;
        end
        // a write to the entry being read is not yet in the registered RAM read data
        bypass_next = req.push && (tail_reg == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            bypass_reg <= bypass_next;
        end
    end

    // bypass data, no reset needed
    always_ff @(posedge clk)
    begin
        bypass_data_reg <= req.push_len;
    end

    // storage, read address follows the next head
    ccls_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.push),
        .waddr (tail_reg),
        .wdata (req.push_len),
        .raddr (head_next),
        .rdata (ram_q)
    );

    // status
    always_comb
    begin
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg == COUNT_W'(QUEUE_DEPTH));
        stat.one_left = (count_reg == COUNT_W'(1));
        stat.head_len = bypass_reg ? bypass_data_reg : ram_q;
    end

    // checks
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.pop && count_reg == '0))
        else $error("pop from empty length queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.push && count_reg == COUNT_W'(QUEUE_DEPTH)))
        else $error("push into full length queue");

endmodule

FILE: sv/ccls_ctrl.sv
// ccls_ctrl: event handling, credit accounting and response parsing.
// Depends on ccls_pkg.
module ccls_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_LINE    = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ev_valid,
    input  ccls_pkg::func_t    ev_func,
    input  logic [7:0]         ev_len,
    input  logic [7:0]         ev_rx,
    input  logic [12:0]        credit_limit,
    input  ccls_pkg::q_stat_t  q_stat,
    output ccls_pkg::q_req_t   q_req,
    output ccls_pkg::result_t  result
);

    localparam int SUM_W = $clog2(QUEUE_DEPTH * MAX_LINE + 1);
    localparam int CMP_W = ((SUM_W > 13) ? SUM_W : 13) + 1;

    ccls_pkg::mode_t  mode_reg, mode_next;
    ccls_pkg::cause_t cause_reg, cause_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             held_valid_reg, held_valid_next;
    logic [7:0]       held_len_reg, held_len_next;
    logic [2:0]       reply_pos_reg, reply_pos_next;
    logic [1:0]       reply_match_reg, reply_match_next;
    logic [31:0]      sent_reg, sent_next;
    logic [31:0]      done_reg, done_next;

    logic [7:0]       len_sat;
    logic [CMP_W-1:0] limit_eff;
    logic [CMP_W-1:0] sum_push;
    logic [CMP_W-1:0] sum_pop;
    logic             reply_ok;
    logic             rel;
    logic [7:0]       rel_len;

    // operands shared by the event paths
    always_comb
    begin
        len_sat   = (ev_len > 8'(MAX_LINE)) ? 8'(MAX_LINE) : ev_len;
        limit_eff = (credit_limit == '0) ? CMP_W'(1) : CMP_W'(credit_limit);
        sum_push  = CMP_W'(sum_reg) + CMP_W'(len_sat);
        sum_pop   = q_stat.empty ? CMP_W'(sum_reg)
                                 : CMP_W'(sum_reg) - CMP_W'(q_stat.head_len);
        reply_ok  = (reply_match_reg[0] && reply_pos_reg >= ccls_pkg::OK_LEN) ||
                    (reply_match_reg[1] && reply_pos_reg >= ccls_pkg::ERR_LEN);
    end

    // next state per event
    always_comb
    begin
        mode_next        = mode_reg;
        cause_next       = cause_reg;
        sum_next         = sum_reg;
        held_valid_next  = held_valid_reg;
        held_len_next    = held_len_reg;
        reply_pos_next   = reply_pos_reg;
        reply_match_next = reply_match_reg;
        sent_next        = sent_reg;
        done_next        = done_reg;
        q_req.push       = 1'b0;
        q_req.pop        = 1'b0;
        q_req.push_len   = len_sat;
        rel              = 1'b0;
        rel_len          = 8'd0;

        if (ev_valid)
        begin
            case (ev_func)
                ccls_pkg::FUNC_ABORT:
                begin
                    mode_next  = ccls_pkg::MODE_ERROR;
                    cause_next = ccls_pkg::CAUSE_ABORT;
                end
                ccls_pkg::FUNC_LINE_READY:
                begin
                    if (mode_reg == ccls_pkg::MODE_STREAM && ev_len != 8'd0)
                    begin
                        if (q_stat.full)
                        begin
                            mode_next  = ccls_pkg::MODE_ERROR;
                            cause_next = ccls_pkg::CAUSE_OVERFLOW;
                        end
                        else
                        begin
                            q_req.push = 1'b1;
                            sum_next   = SUM_W'(sum_push);
                            if (sum_push >= limit_eff)
                            begin
                                held_valid_next = 1'b1;
                                held_len_next   = len_sat;
                                mode_next       = ccls_pkg::MODE_AWAIT;
                            end
                            else
                            begin
                                rel       = 1'b1;
                                rel_len   = len_sat;
                                sent_next = sent_reg + 32'd1;
                            end
                        end
                    end
                end
                ccls_pkg::FUNC_EXHAUSTED:
                begin
                    if (mode_reg == ccls_pkg::MODE_STREAM)
                    begin
                        mode_next = q_stat.empty ? ccls_pkg::MODE_DONE
                                                 : ccls_pkg::MODE_FINISH;
                    end
                end
                ccls_pkg::FUNC_RESPONSE:
                begin
                    if (mode_reg == ccls_pkg::MODE_FINISH)
                    begin
                        // draining: only newlines count
                        if (ev_rx == ccls_pkg::CHAR_LF)
                        begin
                            q_req.pop = !q_stat.empty;
                            sum_next  = SUM_W'(sum_pop);
                            done_next = done_reg + 32'd1;
                            if (q_stat.empty || q_stat.one_left)
                            begin
                                mode_next = ccls_pkg::MODE_DONE;
                            end
                        end
                    end
                    else if ((mode_reg == ccls_pkg::MODE_STREAM ||
                              mode_reg == ccls_pkg::MODE_AWAIT) &&
                             ev_rx != ccls_pkg::CHAR_CR)
                    begin
                        if (ev_rx == ccls_pkg::CHAR_LF)
                        begin
                            // end of a response line
                            reply_pos_next   = 3'd0;
                            reply_match_next = ccls_pkg::MATCH_ALL;
                            if (!reply_ok)
                            begin
                                mode_next  = ccls_pkg::MODE_ERROR;
                                cause_next = ccls_pkg::CAUSE_UNKNOWN;
                            end
                            else
                            begin
                                q_req.pop = !q_stat.empty;
                                sum_next  = SUM_W'(sum_pop);
                                done_next = done_reg + 32'd1;
                                if (mode_reg == ccls_pkg::MODE_AWAIT &&
                                    held_valid_reg && sum_pop < limit_eff)
                                begin
                                    rel             = 1'b1;
                                    rel_len         = held_len_reg;
                                    sent_next       = sent_reg + 32'd1;
                                    held_valid_next = 1'b0;
                                    held_len_next   = 8'd0;
                                    mode_next       = ccls_pkg::MODE_STREAM;
                                end
                            end
                        end
                        else
                        begin
                            // keyword matching
                            if (reply_pos_reg < ccls_pkg::OK_LEN &&
                                ev_rx != ccls_pkg::ok_char(reply_pos_reg))
                            begin
                                reply_match_next = reply_match_next & ~ccls_pkg::MATCH_OK;
                            end
                            if (reply_pos_reg < ccls_pkg::ERR_LEN &&
                                ev_rx != ccls_pkg::err_char(reply_pos_reg))
                            begin
                                reply_match_next = reply_match_next & ~ccls_pkg::MATCH_ERR;
                            end
                            if (reply_pos_reg < ccls_pkg::ERR_LEN)
                            begin
                                reply_pos_next = reply_pos_reg + 3'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        result.release_line   = rel;
        result.release_length = rel_len;
        result.mode           = mode_next;
        result.error_cause    = cause_next;
        result.lines_sent     = sent_next;
        result.lines_done     = done_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ccls_pkg::MODE_STREAM;
            cause_reg       <= ccls_pkg::CAUSE_NONE;
            sum_reg         <= '0;
            held_valid_reg  <= 1'b0;
            held_len_reg    <= 8'd0;
            reply_pos_reg   <= 3'd0;
            reply_match_reg <= ccls_pkg::MATCH_ALL;
            sent_reg        <= 32'd0;
            done_reg        <= 32'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            cause_reg       <= cause_next;
            sum_reg         <= sum_next;
            held_valid_reg  <= held_valid_next;
            held_len_reg    <= held_len_next;
            reply_pos_reg   <= reply_pos_next;
            reply_match_reg <= reply_match_next;
            sent_reg        <= sent_next;
            done_reg        <= done_next;
        end
    end

    // checks
    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> sum_reg == '0)
        else $error("outstanding sum nonzero with empty queue");
    a_await_held: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ccls_pkg::MODE_AWAIT |-> held_valid_reg)
        else $error("awaiting response without a held line");
    a_release_len: assert property (@(posedge clk) disable iff (!rst_n)
        rel |-> rel_len != 8'd0)
        else $error("release with zero length");

endmodule
